/* rtl/assert_macros.svh */
// Assertion macros used by the calibrator top level.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define ALC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Implication checked at the same edge.
`define ALC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/alc_pkg.sv */
// Shared types, constants and arithmetic helpers of the ambient light calibrator.
// No dependencies; used by the front end, queue, arithmetic pipeline and top level.
package alc_pkg;

  localparam int GainSteps  = 7;
  localparam int ItimeSteps = 6;
  localparam int IndexMax   = 7;
  localparam int GainLim    = (GainSteps - 1 < IndexMax) ? GainSteps - 1 : IndexMax;
  localparam int ItimeLim   = (ItimeSteps - 1 < IndexMax) ? ItimeSteps - 1 : IndexMax;
  localparam int QDepth     = 4;

  localparam int Div1000    = 1000;
  localparam logic [30:0] Recip1000 = 31'd1099511627;  // floor(2^40 / 1000)
  localparam int Div5       = 5;
  localparam logic [25:0] Recip5 = 26'd53687091;       // floor(2^28 / 5)

  localparam logic RegPreset = 1'b0;
  localparam logic RegTrim   = 1'b1;
  localparam logic [15:0] TrimDefault = 16'd1000;

  typedef enum logic [1:0] {
    PRESET_A, PRESET_B, PRESET_C, PRESET_D
  } alc_preset_e;

  typedef enum logic [2:0] {
    GOP_X8, GOP_X4, GOP_X1, GOP_HALF, GOP_EIGHTH, GOP_M63
  } alc_gop_e;

  typedef enum logic [2:0] {
    TOP_X4, TOP_X2, TOP_X1, TOP_HALF, TOP_QUARTER, TOP_EIGHTH
  } alc_top_e;

  typedef struct packed {
    alc_preset_e preset;
    logic [15:0] trim;
  } alc_cfg_t;

  typedef struct packed {
    alc_preset_e preset;
    logic [15:0] vis;
    logic [15:0] ir;
    alc_gop_e    gop;
    alc_top_e    top;
    logic [15:0] trim;
    logic        quad;
    logic [2:0]  ng;
    logic [2:0]  nt;
    logic        chg;
  } alc_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } alc_qstat_t;

  typedef struct packed {
    logic [20:0] q;
    logic [9:0]  r;
  } alc_div_t;

  // Exact quotient and remainder by 1000 for values below 2^30.
  function automatic alc_div_t div1000(input logic [29:0] x);
    logic [60:0] prod;
    logic [20:0] q;
    logic [30:0] r;
    prod = 61'(x) * 61'(Recip1000);
    q = prod[60:40];
    r = 31'(x) - 31'(q) * 31'(Div1000);
    if (r >= 31'(Div1000)) begin
      q = q + 21'd1;
      r = r - 31'(Div1000);
    end
    return '{q: q, r: r[9:0]};
  endfunction

  // Exact quotient by 5 for values below 2^25.
  function automatic logic [22:0] div5(input logic [24:0] x);
    logic [50:0] prod;
    logic [22:0] q;
    logic [25:0] r;
    prod = 51'(x) * 51'(Recip5);
    q = prod[50:28];
    r = 26'(x) - 26'(q) * 26'(Div5);
    if (r >= 26'(Div5)) q = q + 23'd1;
    return q;
  endfunction

  function automatic logic [19:0] lux_scale(input alc_preset_e p);
    case (p)
      PRESET_B: return 20'd10000;
      PRESET_C: return 20'd1000000;
      PRESET_D: return 20'd408000;
      default:  return 20'd0;
    endcase
  endfunction

  function automatic logic [15:0] bright_lvl(input alc_preset_e p);
    case (p)
      PRESET_A: return 16'd45000;
      PRESET_B: return 16'd60000;
      PRESET_C: return 16'd65000;
      default:  return 16'd36000;
    endcase
  endfunction

  function automatic logic [15:0] dark_lvl(input alc_preset_e p);
    case (p)
      PRESET_A: return 16'd100;
      PRESET_C: return 16'd10;
      default:  return 16'd50;
    endcase
  endfunction

  function automatic alc_gop_e gain_op(input alc_preset_e p, input logic [2:0] g);
    alc_gop_e op;
    op = GOP_X1;
    if (p == PRESET_A || p == PRESET_D) begin
      case (g)
        3'd0:    op = GOP_X8;
        3'd1:    op = GOP_X4;
        3'd3:    op = GOP_HALF;
        3'd4:    op = (p == PRESET_D) ? GOP_EIGHTH : GOP_X1;
        3'd5:    op = (p == PRESET_D) ? GOP_M63 : GOP_X1;
        default: op = GOP_X1;
      endcase
    end
    return op;
  endfunction

  function automatic alc_top_e time_op(input alc_preset_e p, input logic [2:0] t);
    alc_top_e op;
    op = TOP_X1;
    if (p == PRESET_A || p == PRESET_D) begin
      case (t)
        3'd0:    op = TOP_X4;
        3'd1:    op = TOP_X2;
        3'd3:    op = TOP_HALF;
        3'd4:    op = TOP_QUARTER;
        3'd5:    op = TOP_EIGHTH;
        default: op = TOP_X1;
      endcase
    end
    return op;
  endfunction

endpackage

/* rtl/alc_if.sv */
// Valid/ready channel interfaces for sensor readings and calibrated results.
// No dependencies.
interface alc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] visible_count;
  logic [15:0] infrared_count;
  logic [2:0]  gain_index;
  logic [2:0]  itime_index;

  modport source (output valid, visible_count, infrared_count, gain_index, itime_index,
                  input ready);
  modport sink   (input valid, visible_count, infrared_count, gain_index, itime_index,
                  output ready);
endinterface

interface alc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] illum_mlux;
  logic [31:0] color_temp_kelvin;
  logic [2:0]  next_gain_index;
  logic [2:0]  next_itime_index;
  logic        range_changed;

  modport source (output valid, illum_mlux, color_temp_kelvin, next_gain_index,
                  next_itime_index, range_changed, input ready);
  modport sink   (input valid, illum_mlux, color_temp_kelvin, next_gain_index,
                  next_itime_index, range_changed, output ready);
endinterface

/* rtl/alc_front.sv */
// Front end: accepts readings, decodes preset factors and makes the auto-gain step.
// Depends on alc_pkg and alc_in_if.
module alc_front import alc_pkg::*; (
  alc_in_if.sink   in_if,
  input  alc_cfg_t cfg_i,
  output alc_rec_t rec_o,
  output logic     rec_valid_o,
  input  logic     rec_ready_i
);

  logic [2:0] g;
  logic [2:0] t;
  logic [15:0] vis;

  assign g   = in_if.gain_index;
  assign t   = in_if.itime_index;
  assign vis = in_if.visible_count;

  assign in_if.ready = rec_ready_i;
  assign rec_valid_o = in_if.valid;

  always_comb begin
    rec_o.preset = cfg_i.preset;
    rec_o.vis    = vis;
    rec_o.ir     = in_if.infrared_count;
    rec_o.gop    = gain_op(cfg_i.preset, g);
    rec_o.top    = time_op(cfg_i.preset, t);
    rec_o.trim   = cfg_i.trim;
    rec_o.quad   = (cfg_i.preset == PRESET_A) || (cfg_i.preset == PRESET_D);
    rec_o.ng     = g;
    rec_o.nt     = t;
    rec_o.chg    = 1'b0;
    // step down on saturation, gain first; step up when dark, gain first
    if (vis >= bright_lvl(cfg_i.preset)) begin
      if (g != 3'd0) begin
        rec_o.ng  = g - 3'd1;
        rec_o.chg = 1'b1;
      end else if (t != 3'd0) begin
        rec_o.nt  = t - 3'd1;
        rec_o.chg = 1'b1;
      end
    end else if (vis <= dark_lvl(cfg_i.preset)) begin
      if (g < 3'(GainLim)) begin
        rec_o.ng  = g + 3'd1;
        rec_o.chg = 1'b1;
      end else if (t < 3'(ItimeLim)) begin
        rec_o.nt  = t + 3'd1;
        rec_o.chg = 1'b1;
      end
    end
  end

endmodule

/* rtl/alc_queue.sv */
// Short FIFO between front end and arithmetic pipeline.
// Depends on alc_pkg.
module alc_queue import alc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  alc_rec_t   rec_i,
  input  logic       pop_i,
  output alc_rec_t   rec_o,
  output alc_qstat_t stat_o
);

  localparam int PtrW = $clog2(QDepth);

  alc_rec_t            mem_q [QDepth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]       cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign stat_o.full  = (cnt_q == (PtrW+1)'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign rec_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + PtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= rec_i;
  end

endmodule

/* rtl/alc_back.sv */
// Arithmetic pipeline: lux scaling, pipelined IR/visible divider, color temperature.
// Depends on alc_pkg and alc_out_if.
module alc_back import alc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alc_rec_t rec_i,
  input  logic     rec_valid_i,
  output logic     rec_ready_o,
  alc_out_if.source out_if
);

  localparam int DivBits   = 17;
  localparam int StgGMul   = 1;
  localparam int StgGHi    = 2;
  localparam int StgGLo    = 3;
  localparam int StgTime   = 4;
  localparam int StgTMul   = 5;
  localparam int StgTHi    = 6;
  localparam int StgLux    = 7;
  localparam int StgSq     = DivBits + 1;
  localparam int StgCHi    = DivBits + 2;
  localparam int StgCLo    = DivBits + 3;
  localparam int StgCct    = DivBits + 4;
  localparam int NStg      = StgCct + 1;
  localparam logic [57:0] LuxSat = 58'd4294967296000;  // 1000 * 2^32

  typedef struct packed {
    logic [15:0] vis;
    logic        viszero;
    logic        quad;
    alc_gop_e    gop;
    alc_top_e    top;
    logic [15:0] trim;
    logic [2:0]  ng;
    logic [2:0]  nt;
    logic        chg;
    logic [57:0] lacc;
    logic [20:0] lqh;
    logic [9:0]  lrh;
    logic        lsat;
    logic [31:0] lux;
    logic [15:0] drem;
    logic [16:0] dnum;
    logic [16:0] dq;
    logic        big;
    logic [43:0] cacc;
    logic [20:0] cqh;
    logic [9:0]  crh;
    logic [28:0] ct;
    logic [31:0] cct;
  } alc_stg_t;

  alc_stg_t          cr_q [NStg];
  alc_stg_t          cr_d [NStg];
  logic [NStg-1:0]   vld_q;
  logic              en;

  assign en          = !vld_q[NStg-1] || out_if.ready;
  assign rec_ready_o = en;

  always_comb begin
    logic [25:0] n;
    logic [16:0] rem2;
    logic        ge;
    alc_div_t    dv;
    logic [42:0] x;
    logic [35:0] c;

    // entry stage
    n = 26'(rec_i.ir) * 26'(Div1000);
    cr_d[0]         = '0;
    cr_d[0].vis     = rec_i.vis;
    cr_d[0].viszero = (rec_i.vis == '0);
    cr_d[0].quad    = rec_i.quad;
    cr_d[0].gop     = rec_i.gop;
    cr_d[0].top     = rec_i.top;
    cr_d[0].trim    = rec_i.trim;
    cr_d[0].ng      = rec_i.ng;
    cr_d[0].nt      = rec_i.nt;
    cr_d[0].chg     = rec_i.chg;
    if (rec_i.preset == PRESET_A) begin
      cr_d[0].lacc = 58'(div5(25'(rec_i.vis) * 25'd336));
    end else begin
      cr_d[0].lacc = 58'(36'(rec_i.vis) * 36'(lux_scale(rec_i.preset)));
    end
    cr_d[0].drem = 16'(n[25:17]);
    cr_d[0].dnum = n[16:0];
    // quotient at or above 2^17 saturates the color temperature
    cr_d[0].big  = (16'(n[25:17]) >= rec_i.vis);

    for (int k = 1; k < NStg; k++) cr_d[k] = cr_q[k-1];

    // one quotient bit per stage
    for (int k = 1; k <= DivBits; k++) begin
      rem2 = {cr_q[k-1].drem, cr_q[k-1].dnum[16]};
      ge   = rem2 >= {1'b0, cr_q[k-1].vis};
      cr_d[k].drem = ge ? 16'(rem2 - {1'b0, cr_q[k-1].vis}) : rem2[15:0];
      cr_d[k].dnum = {cr_q[k-1].dnum[15:0], 1'b0};
      cr_d[k].dq   = {cr_q[k-1].dq[15:0], ge};
    end

    // gain factor
    if (cr_q[StgGMul-1].gop == GOP_M63) begin
      cr_d[StgGMul].lacc = 58'(cr_q[StgGMul-1].lacc[35:0] * 42'd63);
    end
    dv = div1000(30'(cr_q[StgGHi-1].lacc[41:20]));
    cr_d[StgGHi].lqh = dv.q;
    cr_d[StgGHi].lrh = dv.r;
    dv = div1000({cr_q[StgGLo-1].lrh, cr_q[StgGLo-1].lacc[19:0]});
    case (cr_q[StgGLo-1].gop)
      GOP_X8:     cr_d[StgGLo].lacc = cr_q[StgGLo-1].lacc << 3;
      GOP_X4:     cr_d[StgGLo].lacc = cr_q[StgGLo-1].lacc << 2;
      GOP_HALF:   cr_d[StgGLo].lacc = cr_q[StgGLo-1].lacc >> 1;
      GOP_EIGHTH: cr_d[StgGLo].lacc = cr_q[StgGLo-1].lacc >> 3;
      GOP_M63:    cr_d[StgGLo].lacc = (58'(cr_q[StgGLo-1].lqh) << 20) + 58'(dv.q);
      default:    cr_d[StgGLo].lacc = cr_q[StgGLo-1].lacc;
    endcase

    // integration-time factor
    case (cr_q[StgTime-1].top)
      TOP_X4:      cr_d[StgTime].lacc = cr_q[StgTime-1].lacc << 2;
      TOP_X2:      cr_d[StgTime].lacc = cr_q[StgTime-1].lacc << 1;
      TOP_HALF:    cr_d[StgTime].lacc = cr_q[StgTime-1].lacc >> 1;
      TOP_QUARTER: cr_d[StgTime].lacc = cr_q[StgTime-1].lacc >> 2;
      TOP_EIGHTH:  cr_d[StgTime].lacc = cr_q[StgTime-1].lacc >> 3;
      default:     cr_d[StgTime].lacc = cr_q[StgTime-1].lacc;
    endcase

    // trim
    cr_d[StgTMul].lacc = 58'(cr_q[StgTMul-1].lacc[41:0]) * 58'(cr_q[StgTMul-1].trim);
    cr_d[StgTHi].lsat  = cr_q[StgTHi-1].lacc >= LuxSat;
    dv = div1000(30'(cr_q[StgTHi-1].lacc[41:20]));
    cr_d[StgTHi].lqh = dv.q;
    cr_d[StgTHi].lrh = dv.r;
    dv = div1000({cr_q[StgLux-1].lrh, cr_q[StgLux-1].lacc[19:0]});
    cr_d[StgLux].lux = cr_q[StgLux-1].lsat ? '1 :
                       32'((32'(cr_q[StgLux-1].lqh) << 20) + 32'(dv.q));

    // color temperature: floor(449 r^2 / 1000) - 3525 r + 6823
    cr_d[StgSq].cacc = 44'(34'(cr_q[StgSq-1].dq) * 34'(cr_q[StgSq-1].dq));
    x = 43'(cr_q[StgCHi-1].cacc[33:0]) * 43'd449;
    dv = div1000(30'(x[42:20]));
    cr_d[StgCHi].cacc = 44'(x);
    cr_d[StgCHi].cqh  = dv.q;
    cr_d[StgCHi].crh  = dv.r;
    cr_d[StgCHi].ct   = 29'(cr_q[StgCHi-1].dq) * 29'd3525;
    dv = div1000({cr_q[StgCLo-1].crh, cr_q[StgCLo-1].cacc[19:0]});
    c = (36'(cr_q[StgCLo-1].cqh) << 20) + 36'(dv.q) + 36'd6823 - 36'(cr_q[StgCLo-1].ct);
    cr_d[StgCLo].cacc = 44'(c);
    c = cr_q[StgCct-1].cacc[35:0];
    if (cr_q[StgCct-1].viszero)        cr_d[StgCct].cct = '0;
    else if (!cr_q[StgCct-1].quad)     cr_d[StgCct].cct = 32'd5000;
    else if (cr_q[StgCct-1].big)       cr_d[StgCct].cct = '1;
    else if ($signed(c) <= 36'sd0)     cr_d[StgCct].cct = 32'd2700;
    else if (c[35:32] != 4'd0)         cr_d[StgCct].cct = '1;
    else                               cr_d[StgCct].cct = c[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], rec_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NStg; k++) cr_q[k] <= cr_d[k];
    end
  end

  assign out_if.valid             = vld_q[NStg-1];
  assign out_if.illum_mlux        = cr_q[NStg-1].lux;
  assign out_if.color_temp_kelvin = cr_q[NStg-1].cct;
  assign out_if.next_gain_index   = cr_q[NStg-1].ng;
  assign out_if.next_itime_index  = cr_q[NStg-1].nt;
  assign out_if.range_changed     = cr_q[NStg-1].chg;

endmodule

/* rtl/ambient_light_calibrator.sv */
// Ambient light calibrator: one reading in, one result out, one item per clock
// sustained while the output is not stalled. A reading is decoded and queued
// (4 entries) at the edge it is accepted; its result then leaves the queue and
// passes through the 22-stage arithmetic pipeline, whose length is set by the
// 17-stage IR/visible divider followed by the squaring and scaling stages of the
// color temperature. The whole pipeline holds while the output is stalled; the
// queue keeps taking items until it is full.
// Registers: preset at 0x0, trim at 0x4.
`include "assert_macros.svh"

module ambient_light_calibrator import alc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  alc_in_if.sink      in_if,
  alc_out_if.source   out_if
);

  alc_cfg_t   cfg_q;
  alc_rec_t   fr_rec, hd_rec;
  logic       fr_valid;
  alc_qstat_t qstat;
  logic       bk_ready;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_comb begin
    case (reg_sel)
      RegPreset: prdata = 32'(cfg_q.preset);
      RegTrim:   prdata = 32'(cfg_q.trim);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.preset <= PRESET_A;
      cfg_q.trim   <= TrimDefault;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        RegPreset: cfg_q.preset <= alc_preset_e'(pwdata[1:0]);
        RegTrim:   cfg_q.trim   <= (pwdata[15:0] == '0) ? TrimDefault : pwdata[15:0];
        default:   cfg_q        <= cfg_q;
      endcase
    end
  end

  alc_front u_front (
    .in_if       (in_if),
    .cfg_i       (cfg_q),
    .rec_o       (fr_rec),
    .rec_valid_o (fr_valid),
    .rec_ready_i (!qstat.full)
  );

  alc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fr_valid),
    .rec_i  (fr_rec),
    .pop_i  (bk_ready),
    .rec_o  (hd_rec),
    .stat_o (qstat)
  );

  alc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (hd_rec),
    .rec_valid_i (!qstat.empty),
    .rec_ready_o (bk_ready),
    .out_if      (out_if)
  );

  `ALC_ASSERT(a_trim_nonzero, cfg_q.trim != '0, "trim register holds zero")
  `ALC_ASSERT_IMP(a_full_blocks, qstat.full, !in_if.ready, "input taken while queue full")
  `ALC_ASSERT_IMP(a_stall_src, !bk_ready, out_if.valid && !out_if.ready,
                  "pipeline held without an output stall")

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for ambient_light_calibrator: readings in, lux/CCT/auto-gain out.
// Depends on alc_pkg, the alc_in_if/alc_out_if channels and the calibrator RTL.
module tb;
  import alc_pkg::*;

  localparam logic [2:0] ADDR_PRESET = 3'd0;
  localparam logic [2:0] ADDR_TRIM   = 3'd4;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [15:0] vis;
    logic [15:0] ir;
    logic [2:0]  gain;
    logic [2:0]  itime;
  } reading_t;

  typedef struct packed {
    logic [31:0] lux;
    logic [31:0] cct;
    logic [2:0]  ngain;
    logic [2:0]  nitime;
    logic        chg;
  } calib_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  alc_in_if  in_if ();
  alc_out_if out_if ();

  ambient_light_calibrator dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  alc_preset_e cur_preset = PRESET_A;
  logic [15:0] cur_trim = 16'd1000;
  reading_t readings_q[$];
  calib_t   calib_q[$];
  int errors = 0;
  int results_seen = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_off = 0;
  bit calm = 1'b0;
  int cycles = 0;

  function automatic longint unsigned gain_mult(alc_preset_e p, logic [2:0] g);
    if (g >= 3'd7) return 0;
    case (p)
      PRESET_A, PRESET_D: begin
        case (g)
          3'd0: return 8000;
          3'd1: return 4000;
          3'd2: return 1000;
          3'd3: return 500;
          3'd4: return (p == PRESET_D) ? 125 : 0;
          3'd5: return (p == PRESET_D) ? 63 : 0;
          default: return 0;
        endcase
      end
      default: return (g < 3'd4) ? 1000 : 0;
    endcase
  endfunction

  function automatic longint unsigned time_factor(alc_preset_e p, logic [2:0] t);
    if (t >= 3'd6) return 0;
    case (p)
      PRESET_A, PRESET_D: return 64'd4000 >> t;
      PRESET_B: return (t == 3'd2 || t == 3'd5) ? 1000 : 0;
      default:  return (t == 3'd2) ? 1000 : 0;
    endcase
  endfunction

  function automatic calib_t calibrate(reading_t rd, alc_preset_e p, logic [15:0] trim);
    calib_t c;
    longint unsigned num, den, v, gf, tf, bright, dark, r, r2, qa;
    longint signed qb, qc, sq, ct;
    case (p)
      PRESET_A: begin num = 672;  den = 10000; bright = 45000; dark = 100; end
      PRESET_B: begin num = 10;   den = 1;     bright = 60000; dark = 50;  end
      PRESET_C: begin num = 1000; den = 1;     bright = 65000; dark = 10;  end
      default:  begin num = 408;  den = 1;     bright = 36000; dark = 50;  end
    endcase
    if (p == PRESET_A || p == PRESET_D) begin
      qa = 449000; qb = -3525000; qc = 6823;
    end else begin
      qa = 0; qb = 0; qc = 5000;
    end
    v = 64'(rd.vis) * num * 1000 / den;
    gf = gain_mult(p, rd.gain);
    tf = time_factor(p, rd.itime);
    if (gf > 0) v = v * gf / 1000;
    if (tf > 0) v = v * tf / 1000;
    v = v * trim / 1000;
    c.lux = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    if (rd.vis == 0) c.cct = 0;
    else if (qa == 0 && qb == 0) c.cct = qc[31:0];
    else begin
      r = 64'(rd.ir) * 1000 / rd.vis;
      r2 = r * r;
      sq = longint'(qa * (r2 / 1000000) + qa * (r2 % 1000000) / 1000000);
      ct = sq + qb * longint'(r) / 1000 + qc;
      if (ct <= 0) c.cct = 32'd2700;
      else c.cct = (ct > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : ct[31:0];
    end
    c.ngain = rd.gain;
    c.nitime = rd.itime;
    c.chg = 1'b0;
    if (rd.vis >= bright) begin
      if (rd.gain > 0) begin c.ngain = rd.gain - 3'd1; c.chg = 1'b1; end
      else if (rd.itime > 0) begin c.nitime = rd.itime - 3'd1; c.chg = 1'b1; end
    end else if (rd.vis <= dark) begin
      if (rd.gain < 3'(GainSteps - 1)) begin c.ngain = rd.gain + 3'd1; c.chg = 1'b1; end
      else if (rd.itime < 3'(ItimeSteps - 1)) begin
        c.nitime = rd.itime + 3'd1; c.chg = 1'b1;
      end
    end
    return c;
  endfunction

  // Sender: predict on accept, then hold, idle or offer the next reading.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.visible_count <= '0;
      in_if.infrared_count <= '0;
      in_if.gain_index <= '0;
      in_if.itime_index <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        calib_q.push_back(calibrate(readings_q.pop_front(), cur_preset, cur_trim));
        send_gap = calm ? 0 : $urandom_range(0, 3);
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the offered item
      end else if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (readings_q.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.visible_count <= readings_q[0].vis;
        in_if.infrared_count <= readings_q[0].ir;
        in_if.gain_index <= readings_q[0].gain;
        in_if.itime_index <= readings_q[0].itime;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: check each result, then stall at random or for a long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      cycles++;
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (calib_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result lux=%0d cct=%0d", $time, out_if.illum_mlux,
                   out_if.color_temp_kelvin);
        end else begin
          calib_t e;
          e = calib_q.pop_front();
          if (out_if.illum_mlux !== e.lux) begin
            errors++;
            $display("%0t: illum_mlux exp %0d got %0d", $time, e.lux, out_if.illum_mlux);
          end
          if (out_if.color_temp_kelvin !== e.cct) begin
            errors++;
            $display("%0t: color_temp_kelvin exp %0d got %0d", $time, e.cct,
                     out_if.color_temp_kelvin);
          end
          if (out_if.next_gain_index !== e.ngain) begin
            errors++;
            $display("%0t: next_gain_index exp %0d got %0d", $time, e.ngain,
                     out_if.next_gain_index);
          end
          if (out_if.next_itime_index !== e.nitime) begin
            errors++;
            $display("%0t: next_itime_index exp %0d got %0d", $time, e.nitime,
                     out_if.next_itime_index);
          end
          if (out_if.range_changed !== e.chg) begin
            errors++;
            $display("%0t: range_changed exp %0d got %0d", $time, e.chg,
                     out_if.range_changed);
          end
        end
        recv_gap = calm ? 0 : $urandom_range(0, 3);
      end
      if (hold_off > 0) begin
        hold_off--;
        out_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_PRESET) cur_preset = alc_preset_e'(data[1:0]);
    else cur_trim = (data[15:0] == 16'd0) ? 16'd1000 : data[15:0];
  endtask

  task automatic drain();
    wait (readings_q.size() == 0 && !in_if.valid && calib_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic add(input int vis, input int ir, input int g, input int t);
    readings_q.push_back('{vis: 16'(vis), ir: 16'(ir), gain: 3'(g), itime: 3'(t)});
  endtask

  task automatic add_random();
    int vis, ir;
    case ($urandom_range(0, 3))
      0: vis = $urandom_range(0, 150);
      1: vis = $urandom_range(35000, 65535);
      default: vis = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 2))
      0: ir = (vis * $urandom_range(0, 6)) & 16'hFFFF;
      default: ir = $urandom_range(0, 65535);
    endcase
    add(vis, ir, ($urandom_range(0, 7) == 0) ? 7 : $urandom_range(0, 6),
        ($urandom_range(0, 7) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    calm = 1'b1;
    // directed readings under the first preset
    add(0, 0, 0, 0);
    add(0, 65535, 6, 5);
    add(65535, 65535, 0, 0);
    add(65535, 0, 0, 3);
    add(65535, 1234, 4, 7);
    add(45000, 1000, 3, 2);
    add(44999, 1000, 2, 2);
    add(100, 200, 6, 3);
    add(100, 50, 6, 5);
    add(101, 50, 5, 1);
    add(50, 25, 7, 4);
    add(50, 25, 7, 7);
    add(20, 20, 1, 6);
    add(1000, 4000, 2, 2);
    add(1000, 2500, 2, 2);
    add(1, 65535, 4, 4);
    add(30000, 30000, 5, 0);
    add(12345, 6000, 6, 1);
    drain();
    reg_write(ADDR_PRESET, 32'(PRESET_D));
    reg_write(ADDR_TRIM, 32'd65535);
    calm = 1'b0;
    add(65535, 1, 0, 0);
    add(36000, 100, 5, 4);
    add(50, 0, 6, 5);
    add(1000, 4000, 4, 5);
    for (int i = 0; i < 225; i++) add_random();
    // long stall on the receiver while readings keep coming
    hold_off = 150;
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin reg_write(ADDR_PRESET, 32'(PRESET_B)); reg_write(ADDR_TRIM, 32'd1); end
        1: begin reg_write(ADDR_PRESET, 32'(PRESET_C)); reg_write(ADDR_TRIM, 32'd0); end
        2: begin
          reg_write(ADDR_PRESET, 32'(PRESET_A));
          reg_write(ADDR_TRIM, $urandom_range(1, 65535));
        end
        default: begin
          reg_write(ADDR_PRESET, $urandom_range(0, 3));
          reg_write(ADDR_TRIM, $urandom_range(0, 65535));
        end
      endcase
      calm = (ph == 2);
      for (int i = 0; i < 225; i++) add_random();
      drain();
    end
    $display("%0d results checked over all four presets, trim extremes and the zero-trim load,",
             results_seen);
    $display("with random and no idling and a long output stall; %0d mismatches", errors);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
